FILE: hw/rtl/idct_8x8_recon_defines.svh
// assertion macros for the checker file of the idct block
`ifndef IDCT_8X8_RECON_DEFINES_SVH
`define IDCT_8X8_RECON_DEFINES_SVH

// property checked on every clock edge outside reset
`define IDCT_ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked on every clock edge, reset included
`define IDCT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hw/rtl/idct_pkg.sv
// shared types, constants and cosine factors of the 8x8 idct block
package idct_pkg;

  localparam int COEF_BITS_DEF = 16;
  localparam int DATA_W = 16;
  localparam int PIX_W = 8;
  localparam int ACC_W = 22;
  localparam int OPD_W = 19;
  localparam int KC_W = 17;
  localparam int PROD_W = OPD_W + KC_W + 1;
  localparam int MUL_SHIFT = 16;
  localparam int OUT_SHIFT = 4;

  // cosine factors in unsigned 17-bit fixed point with 16 fraction bits
  localparam logic [KC_W-1:0] K1 = 17'd64277;
  localparam logic [KC_W-1:0] K2 = 17'd60547;
  localparam logic [KC_W-1:0] K3 = 17'd54491;
  localparam logic [KC_W-1:0] K4 = 17'd46341;
  localparam logic [KC_W-1:0] K5 = 17'd36410;
  localparam logic [KC_W-1:0] K6 = 17'd25080;
  localparam logic [KC_W-1:0] K7 = 17'd12785;

  // rounding and intra bias added to the even part of the second pass
  localparam logic signed [ACC_W-1:0] EADD_INTER = 22'sd8;
  localparam logic signed [ACC_W-1:0] EADD_INTRA = 22'sd2056;

  typedef struct packed {
    logic signed [DATA_W-1:0] coefficient;
    logic [PIX_W-1:0]         pred_pixel;
    logic                     mode;
  } in_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             last;
  } out_t;

  // block buffer write from the loader
  typedef struct packed {
    logic                     en;
    logic                     bank;
    logic [5:0]               idx;
    logic signed [DATA_W-1:0] coef;
    logic [PIX_W-1:0]         pred;
  } wr_t;

  // block buffer read from the transform engine
  typedef struct packed {
    logic       bank;
    logic [5:0] coef_idx;
    logic [5:0] pred_idx;
  } rd_t;

  // one loaded block waiting for the transform
  typedef struct packed {
    logic bank;
    logic intra;
  } desc_t;

endpackage

FILE: hw/rtl/idct_front.sv
// loader: counts items of a block into a free buffer bank and queues the block
module idct_front #(
  parameter int COEF_BITS = idct_pkg::COEF_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  idct_pkg::in_t  in_data,
  output idct_pkg::wr_t  wr,
  output logic           push,
  output idct_pkg::desc_t push_desc,
  input  logic           blk_done
);
  import idct_pkg::*;

  localparam int SHIFT = DATA_W - COEF_BITS;

  logic [5:0] load_cnt_r;
  logic       bank_r;
  logic [1:0] inflight_r;
  logic [1:0] inflight_nxt;
  logic       accept;
  logic signed [DATA_W-1:0] coef_sh;
  logic signed [DATA_W-1:0] coef_ext;

  // both banks busy means no room for another block
  assign in_ready = (inflight_r != 2'd2);
  assign accept   = in_valid && in_ready;

  // keep the low COEF_BITS bits, sign extended
  assign coef_sh  = in_data.coefficient <<< SHIFT;
  assign coef_ext = coef_sh >>> SHIFT;

  assign wr.en   = accept;
  assign wr.bank = bank_r;
  assign wr.idx  = load_cnt_r;
  assign wr.coef = coef_ext;
  assign wr.pred = in_data.pred_pixel;

  assign push            = accept && (load_cnt_r == 6'd63);
  assign push_desc.bank  = bank_r;
  assign push_desc.intra = in_data.mode;

  always_comb begin
    inflight_nxt = inflight_r;
    if (push && !blk_done) begin
      inflight_nxt = inflight_r + 2'd1;
    end else if (!push && blk_done) begin
      inflight_nxt = inflight_r - 2'd1;
    end
  end

  // item counter, bank toggle and count of blocks in flight
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_cnt_r <= '0;
      bank_r     <= 1'b0;
      inflight_r <= '0;
    end else begin
      inflight_r <= inflight_nxt;
      if (accept) begin
        load_cnt_r <= load_cnt_r + 6'd1;
      end
      if (push) begin
        bank_r <= ~bank_r;
      end
    end
  end

endmodule

FILE: hw/rtl/idct_queue.sv
// two-entry queue of loaded blocks between loader and transform engine
module idct_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  idct_pkg::desc_t push_desc,
  input  logic            pop,
  output logic            empty,
  output idct_pkg::desc_t head
);
  import idct_pkg::*;

  desc_t      ent_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;

  assign empty = (cnt_r == 2'd0);
  assign head  = ent_r[rd_ptr_r];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (!push && pop) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_desc;
    end
  end

endmodule

FILE: hw/rtl/idct_bufs.sv
// ping-pong block buffers for coefficients and predictor pixels
module idct_bufs (
  input  logic                                  clk,
  input  idct_pkg::wr_t                         wr,
  input  idct_pkg::rd_t                         rd,
  output logic signed [idct_pkg::DATA_W-1:0]    coef_q,
  output logic [idct_pkg::PIX_W-1:0]            pred_q
);
  import idct_pkg::*;

  logic signed [DATA_W-1:0] coef_mem [128];
  logic [PIX_W-1:0]         pred_mem [128];
  logic signed [DATA_W-1:0] coef_q_r;
  logic [PIX_W-1:0]         pred_q_r;

  // write from the loader
  always_ff @(posedge clk) begin
    if (wr.en) begin
      coef_mem[{wr.bank, wr.idx}] <= wr.coef;
      pred_mem[{wr.bank, wr.idx}] <= wr.pred;
    end
  end

  // registered reads for the engine
  always_ff @(posedge clk) begin
    coef_q_r <= coef_mem[{rd.bank, rd.coef_idx}];
    pred_q_r <= pred_mem[{rd.bank, rd.pred_idx}];
  end

  assign coef_q = coef_q_r;
  assign pred_q = pred_q_r;

endmodule

FILE: hw/rtl/idct_back.sv
// transform engine: two butterfly passes on a shared multiplier, then pixel output
module idct_back (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               empty,
  input  idct_pkg::desc_t                    head,
  output logic                               pop,
  output logic                               blk_done,
  output idct_pkg::rd_t                      rd,
  input  logic signed [idct_pkg::DATA_W-1:0] coef_q,
  input  logic [idct_pkg::PIX_W-1:0]         pred_q,
  output logic                               out_valid,
  input  logic                               out_ready,
  output idct_pkg::out_t                     out_data
);
  import idct_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_LOAD = 6'b000010,
    S_MUL  = 6'b000100,
    S_WR   = 6'b001000,
    S_ORD  = 6'b010000,
    S_OVAL = 6'b100000
  } state_t;

  state_t     st_r;
  logic       pass_r;
  logic [2:0] col_r;
  logic [3:0] cnt_r;
  logic [5:0] ocnt_r;
  logic       bank_r;
  logic       intra_r;

  logic signed [DATA_W-1:0] x_r [8];
  logic signed [ACC_W-1:0]  a_r, b_r, c_r, d_r, e_r, f_r, g_r, h_r, ad_r, bd_r;

  logic signed [DATA_W-1:0] work_mem [64];
  logic signed [DATA_W-1:0] work_q_r;
  logic [PIX_W-1:0]         pix_mem [64];
  logic [PIX_W-1:0]         pix_q_r;

  logic [2:0]               ld_k;
  logic [2:0]               wk;
  logic [KC_W-1:0]          kc;
  logic signed [OPD_W-1:0]  opnd;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  mres;
  logic signed [ACC_W-1:0]  eadd;
  logic signed [ACC_W-1:0]  gd, ed, cd, dd, add, fd, hd, bdd;
  logic signed [ACC_W-1:0]  o_k;
  logic signed [ACC_W-1:0]  v;
  logic signed [ACC_W-1:0]  sum;
  logic [PIX_W-1:0]         pix;
  logic                     ac;
  logic                     dc_hold;
  logic                     out_acc;

  assign ld_k = 3'(cnt_r - 4'd1);
  assign wk   = 3'(cnt_r - 4'd1);

  // buffer read addresses
  assign rd.bank     = bank_r;
  assign rd.coef_idx = {cnt_r[2:0], col_r};
  assign rd.pred_idx = {cnt_r[2:0], col_r};

  assign pop       = (st_r == S_IDLE) && !empty;
  assign out_valid = (st_r == S_OVAL);
  assign out_acc   = out_valid && out_ready;
  assign out_data.pixel = pix_q_r;
  assign out_data.last  = (ocnt_r == 6'd63);
  assign blk_done  = out_acc && (ocnt_r == 6'd63);

  // multiplier operand selection per step
  always_comb begin
    unique case (cnt_r)
      4'd0:    begin kc = K1; opnd = OPD_W'(x_r[1]); end
      4'd1:    begin kc = K7; opnd = OPD_W'(x_r[7]); end
      4'd2:    begin kc = K7; opnd = OPD_W'(x_r[1]); end
      4'd3:    begin kc = K1; opnd = OPD_W'(x_r[7]); end
      4'd4:    begin kc = K3; opnd = OPD_W'(x_r[3]); end
      4'd5:    begin kc = K5; opnd = OPD_W'(x_r[5]); end
      4'd6:    begin kc = K3; opnd = OPD_W'(x_r[5]); end
      4'd7:    begin kc = K5; opnd = OPD_W'(x_r[3]); end
      4'd8:    begin kc = K4; opnd = OPD_W'(x_r[0]) + OPD_W'(x_r[4]); end
      4'd9:    begin kc = K4; opnd = OPD_W'(x_r[0]) - OPD_W'(x_r[4]); end
      4'd10:   begin kc = K2; opnd = OPD_W'(x_r[2]); end
      4'd11:   begin kc = K6; opnd = OPD_W'(x_r[6]); end
      4'd12:   begin kc = K6; opnd = OPD_W'(x_r[2]); end
      4'd13:   begin kc = K2; opnd = OPD_W'(x_r[6]); end
      4'd14:   begin kc = K4; opnd = OPD_W'(a_r - c_r); end
      default: begin kc = K4; opnd = OPD_W'(b_r - d_r); end
    endcase
  end

  assign prod = $signed({1'b0, kc}) * opnd;
  assign mres = ACC_W'(prod >>> MUL_SHIFT);
  assign eadd = !pass_r ? '0 : (intra_r ? EADD_INTRA : EADD_INTER);

  // output butterfly
  assign cd  = a_r + c_r;
  assign dd  = b_r + d_r;
  assign ed  = e_r - g_r;
  assign gd  = e_r + g_r;
  assign add = f_r + ad_r;
  assign bdd = bd_r - h_r;
  assign fd  = f_r - ad_r;
  assign hd  = bd_r + h_r;

  always_comb begin
    unique case (wk)
      3'd0:    o_k = gd + cd;
      3'd1:    o_k = add + hd;
      3'd2:    o_k = add - hd;
      3'd3:    o_k = ed + dd;
      3'd4:    o_k = ed - dd;
      3'd5:    o_k = fd + bdd;
      3'd6:    o_k = fd - bdd;
      default: o_k = gd - cd;
    endcase
  end

  // reconstruction with clipping and the dc-only inter shortcut
  assign ac = (x_r[1] != '0) || (x_r[2] != '0) || (x_r[3] != '0) || (x_r[4] != '0)
           || (x_r[5] != '0) || (x_r[6] != '0) || (x_r[7] != '0);
  assign dc_hold = !intra_r && !ac && (x_r[0][DATA_W-1] || (x_r[0] == '0));
  assign v   = o_k >>> OUT_SHIFT;
  assign sum = intra_r ? v : v + ACC_W'($signed({1'b0, pred_q}));

  always_comb begin
    if (dc_hold) begin
      pix = pred_q;
    end else if (sum[ACC_W-1]) begin
      pix = '0;
    end else if (sum > ACC_W'(255)) begin
      pix = '1;
    end else begin
      pix = sum[PIX_W-1:0];
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= S_IDLE;
      pass_r <= 1'b0;
      col_r  <= '0;
      cnt_r  <= '0;
      ocnt_r <= '0;
    end else begin
      unique case (st_r)
        S_IDLE: begin
          if (pop) begin
            pass_r <= 1'b0;
            col_r  <= '0;
            cnt_r  <= '0;
            st_r   <= S_LOAD;
          end
        end
        S_LOAD: begin
          if (cnt_r == 4'd8) begin
            cnt_r <= '0;
            st_r  <= S_MUL;
          end else begin
            cnt_r <= cnt_r + 4'd1;
          end
        end
        S_MUL: begin
          cnt_r <= cnt_r + 4'd1;
          if (cnt_r == 4'd15) begin
            st_r <= S_WR;
          end
        end
        S_WR: begin
          if (cnt_r == 4'd8) begin
            cnt_r <= '0;
            col_r <= col_r + 3'd1;
            if (col_r != 3'd7) begin
              st_r <= S_LOAD;
            end else if (!pass_r) begin
              pass_r <= 1'b1;
              st_r   <= S_LOAD;
            end else begin
              ocnt_r <= '0;
              st_r   <= S_ORD;
            end
          end else begin
            cnt_r <= cnt_r + 4'd1;
          end
        end
        S_ORD: begin
          st_r <= S_OVAL;
        end
        S_OVAL: begin
          if (out_acc) begin
            if (ocnt_r == 6'd63) begin
              st_r <= S_IDLE;
            end else begin
              ocnt_r <= ocnt_r + 6'd1;
              st_r   <= S_ORD;
            end
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  // datapath registers and working memories
  always_ff @(posedge clk) begin
    work_q_r <= work_mem[{col_r, cnt_r[2:0]}];
    pix_q_r  <= pix_mem[ocnt_r];
    if (pop) begin
      bank_r  <= head.bank;
      intra_r <= head.intra;
    end
    if ((st_r == S_LOAD) && (cnt_r != 4'd0)) begin
      x_r[ld_k] <= pass_r ? work_q_r : coef_q;
    end
    if (st_r == S_MUL) begin
      unique case (cnt_r)
        4'd0:    a_r  <= mres;
        4'd1:    a_r  <= a_r + mres;
        4'd2:    b_r  <= mres;
        4'd3:    b_r  <= b_r - mres;
        4'd4:    c_r  <= mres;
        4'd5:    c_r  <= c_r + mres;
        4'd6:    d_r  <= mres;
        4'd7:    d_r  <= d_r - mres;
        4'd8:    e_r  <= mres + eadd;
        4'd9:    f_r  <= mres + eadd;
        4'd10:   g_r  <= mres;
        4'd11:   g_r  <= g_r + mres;
        4'd12:   h_r  <= mres;
        4'd13:   h_r  <= h_r - mres;
        4'd14:   ad_r <= mres;
        default: bd_r <= mres;
      endcase
    end
    if ((st_r == S_WR) && (cnt_r != 4'd0)) begin
      if (!pass_r) begin
        work_mem[{wk, col_r}] <= o_k[DATA_W-1:0];
      end else begin
        pix_mem[{wk, col_r}] <= pix;
      end
    end
  end

endmodule

FILE: hw/rtl/idct_8x8_recon.sv
// top level of the 8x8 inverse dct with reconstruction
// Takes 64 transactions per block (coefficient in storage order, predictor in
// raster order, mode sampled on the 64th) at one per cycle into one of two block
// buffers, so a block loads while the previous one is transformed. The engine runs
// both passes through one shared multiplier: per column a load, a multiply and a
// write phase, then it sends 64 pixels in raster order, each read from the pixel
// memory and then offered; the engine takes a block from the queue in its idle
// state. Loading stalls only when both buffers hold blocks not yet fully sent.
module idct_8x8_recon #(
  parameter int COEF_BITS = idct_pkg::COEF_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  idct_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output idct_pkg::out_t out_data
);
  import idct_pkg::*;

  wr_t                      wr;
  rd_t                      rd;
  desc_t                    push_desc;
  desc_t                    head;
  logic                     push;
  logic                     pop;
  logic                     empty;
  logic                     blk_done;
  logic signed [DATA_W-1:0] coef_q;
  logic [PIX_W-1:0]         pred_q;

  // loader
  idct_front #(.COEF_BITS(COEF_BITS)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .wr        (wr),
    .push      (push),
    .push_desc (push_desc),
    .blk_done  (blk_done)
  );

  // block queue
  idct_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_desc (push_desc),
    .pop       (pop),
    .empty     (empty),
    .head      (head)
  );

  // block buffers
  idct_bufs u_bufs (
    .clk    (clk),
    .wr     (wr),
    .rd     (rd),
    .coef_q (coef_q),
    .pred_q (pred_q)
  );

  // transform engine
  idct_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .empty     (empty),
    .head      (head),
    .pop       (pop),
    .blk_done  (blk_done),
    .rd        (rd),
    .coef_q    (coef_q),
    .pred_q    (pred_q),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

FILE: hw/rtl/idct_chk.sv
// port checker for the idct block and its bind
`include "idct_8x8_recon_defines.svh"

module idct_chk (
  input logic           clk,
  input logic           rst_n,
  input logic           in_ready,
  input logic           out_valid,
  input logic           out_ready,
  input idct_pkg::out_t out_data
);

  // stalled pixel holds
  `IDCT_ASSERT_CLK(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_data), "stalled pixel changed")

  // valid drops after a transaction while the next pixel is fetched from the pixel memory
  `IDCT_ASSERT_CLK(a_out_gap, out_valid && out_ready |=> !out_valid, "pixel valid right after a transaction")

  // after reset both buffers are free
  `IDCT_ASSERT_ALWAYS(a_rst_ready, (rst_n && !$past(rst_n)) |-> in_ready, "not ready after reset")

endmodule

bind idct_8x8_recon idct_chk u_chk (.*);
